[rtl/core/random_permutation_shuffle_defines.svh]
// ----------------------------------------------------------------------------
// Random permutation shuffle: assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RANDOM_PERMUTATION_SHUFFLE_DEFINES_SVH
`define RANDOM_PERMUTATION_SHUFFLE_DEFINES_SVH

`ifndef SYNTH
`define RPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define RPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RPS_ASSERT(lbl, clk, rst_n, prop)
`define RPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/rps_pkg.sv]
// ----------------------------------------------------------------------------
// Random permutation shuffle: package
// Shared constants and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package rps_pkg;

    localparam int          MAX_LEN_DEF = 16;
    localparam int          VALUE_W     = 8;
    localparam logic [31:0] LCG_MUL     = 32'd1103515245;
    localparam logic [31:0] LCG_INC     = 32'd12345;
    localparam logic [31:0] RNG_SEED    = 32'h0000_ABCD;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_SHUFFLE = 1'b1;

    typedef struct packed {
        logic load;
        logic shuf_start;
        logic lcg_step;
        logic mod_step;
        logic rd_pair;
        logic wr_i;
        logic wr_j;
        logic i_dec;
        logic emit_start;
        logic rd_emit;
        logic out_load;
        logic k_inc;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic cnt_zero;
        logic cnt_lt2;
        logic mod_last;
        logic i_one;
        logic k_last;
    } status_t;

endpackage

[rtl/core/rps_dp.sv]
// ----------------------------------------------------------------------------
// Random permutation shuffle: datapath
// Element memory, fill count, LCG, bit-serial modulo unit and output register.
// ----------------------------------------------------------------------------
`include "random_permutation_shuffle_defines.svh"

module rps_dp #(
    parameter int MAX_LEN = rps_pkg::MAX_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rps_pkg::cmd_t                cmd,
    input  logic [rps_pkg::VALUE_W-1:0]  value,
    output rps_pkg::status_t             status,
    output logic [rps_pkg::VALUE_W-1:0]  element,
    output logic                         last
);

    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int DW = rps_pkg::VALUE_W;

    logic [DW-1:0] mem [MAX_LEN];

    logic [CW-1:0] count_reg;
    logic [31:0]   rng_reg;
    logic [31:0]   rng_next;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] k_reg;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] rem_next;
    logic [CW:0]   rem_sh;
    logic [CW:0]   divisor;
    logic [DW-1:0] div_reg;
    logic [2:0]    bit_cnt_reg;
    logic [DW-1:0] rd_a_reg;
    logic [DW-1:0] rd_b_reg;
    logic [DW-1:0] out_data_reg;
    logic          out_last_reg;
    logic [CW-1:0] cnt_m1;
    logic [IW-1:0] j_idx;
    logic [IW-1:0] addr_a;
    logic [IW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic          we;

    assign rng_next = rng_reg * rps_pkg::LCG_MUL + rps_pkg::LCG_INC;
    assign cnt_m1   = count_reg - CW'(1);
    assign j_idx    = rem_reg[IW-1:0];

    assign divisor  = (CW + 1)'(i_reg) + (CW + 1)'(1);
    assign rem_sh   = {rem_reg, div_reg[DW-1]};
    assign rem_next = (rem_sh >= divisor) ? CW'(rem_sh - divisor) : CW'(rem_sh);

    assign status.full     = (count_reg == CW'(MAX_LEN));
    assign status.cnt_zero = (count_reg == '0);
    assign status.cnt_lt2  = (count_reg < CW'(2));
    assign status.mod_last = (bit_cnt_reg == 3'd7);
    assign status.i_one    = (i_reg == IW'(1));
    assign status.k_last   = ((CW'(k_reg) + CW'(1)) == count_reg);

    assign addr_a = cmd.rd_emit ? k_reg : i_reg;
    assign we     = (cmd.load && !status.full) || cmd.wr_i || cmd.wr_j;

    always_comb
    begin
        if (cmd.load)
        begin
            waddr = count_reg[IW-1:0];
            wdata = value;
        end
        else if (cmd.wr_i)
        begin
            waddr = i_reg;
            wdata = rd_b_reg;
        end
        else
        begin
            waddr = j_idx;
            wdata = rd_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_pair || cmd.rd_emit)
        begin
            rd_a_reg <= mem[addr_a];
        end
        if (cmd.rd_pair)
        begin
            rd_b_reg <= mem[j_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rng_reg   <= rps_pkg::RNG_SEED;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.load && !status.full)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.lcg_step)
            begin
                rng_reg <= rng_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shuf_start)
        begin
            i_reg <= cnt_m1[IW-1:0];
        end
        else if (cmd.i_dec)
        begin
            i_reg <= i_reg - IW'(1);
        end

        if (cmd.lcg_step)
        begin
            div_reg     <= rng_next[15:8];
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            div_reg     <= {div_reg[DW-2:0], 1'b0};
            rem_reg     <= rem_next;
            bit_cnt_reg <= bit_cnt_reg + 3'd1;
        end

        if (cmd.emit_start)
        begin
            k_reg <= '0;
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + IW'(1);
        end

        if (cmd.out_load)
        begin
            out_data_reg <= rd_a_reg;
            out_last_reg <= status.k_last;
        end
    end

    assign element = out_data_reg;
    assign last    = out_last_reg;

    `RPS_ASSERT(a_dp_count_bound, clk, rst_n, count_reg <= CW'(MAX_LEN))
    `RPS_ASSERT_NEXT(a_dp_full_drop, clk, rst_n, cmd.load && status.full && !cmd.clear,
                     $stable(count_reg))
    `RPS_ASSERT_IMP(a_dp_j_range, clk, rst_n, cmd.rd_pair, rem_reg <= CW'(i_reg))

endmodule

[rtl/core/rps_ctrl.sv]
// ----------------------------------------------------------------------------
// Random permutation shuffle: controller
// Sequences loads, the swap loop and the element emission.
// ----------------------------------------------------------------------------
`include "random_permutation_shuffle_defines.svh"

module rps_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tuser,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  rps_pkg::status_t status,
    output rps_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_LCG       = 4'd1;
    localparam logic [3:0] S_MOD       = 4'd2;
    localparam logic [3:0] S_RD        = 4'd3;
    localparam logic [3:0] S_WR_I      = 4'd4;
    localparam logic [3:0] S_WR_J      = 4'd5;
    localparam logic [3:0] S_EMIT_RD   = 4'd6;
    localparam logic [3:0] S_EMIT_LD   = 4'd7;
    localparam logic [3:0] S_EMIT_WAIT = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == rps_pkg::CMD_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (status.cnt_zero)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else if (status.cnt_lt2)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = S_EMIT_RD;
                    end
                    else
                    begin
                        cmd.shuf_start = 1'b1;
                        state_next     = S_LCG;
                    end
                end
            end
            S_LCG:
            begin
                cmd.lcg_step = 1'b1;
                state_next   = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_last)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd_pair = 1'b1;
                state_next  = S_WR_I;
            end
            S_WR_I:
            begin
                cmd.wr_i   = 1'b1;
                state_next = S_WR_J;
            end
            S_WR_J:
            begin
                cmd.wr_j = 1'b1;
                if (status.i_one)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_EMIT_RD;
                end
                else
                begin
                    cmd.i_dec  = 1'b1;
                    state_next = S_LCG;
                end
            end
            S_EMIT_RD:
            begin
                cmd.rd_emit = 1'b1;
                state_next  = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (status.k_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.k_inc  = 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `RPS_ASSERT_NEXT(a_ctrl_shuf_go, clk, rst_n,
                     s_tvalid && s_tready && s_tuser && !status.cnt_lt2,
                     state_reg == S_LCG)
    `RPS_ASSERT_NEXT(a_ctrl_emit_end, clk, rst_n,
                     m_tvalid && m_tready && status.k_last, state_reg == S_IDLE)
    `RPS_ASSERT_IMP(a_ctrl_no_overlap, clk, rst_n, s_tready, !m_tvalid)

endmodule

[rtl/core/random_permutation_shuffle.sv]
// ----------------------------------------------------------------------------
// Random permutation shuffle: top level
// Byte store that permutes its contents with a Fisher-Yates pass on request.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one request per handshake: tuser low appends tdata to
//   the store (dropped once MAX_LEN bytes are held), tuser high shuffles the
//   store and streams it out on the master side, tlast on the final byte.
//   A shuffle of n bytes runs n-1 swap steps, each made of one LCG
//   multiply, a pass of the bit-serial modulo unit, one paired memory
//   read and two memory writes; then the bytes are emitted one at a time.
//   An empty store emits nothing; one byte emits at once.
//   No new request is taken until the last byte has been handed over.
//   Reset empties the store and reseeds the LCG to 0xABCD; the LCG state
//   then carries over from one shuffle to the next.
//   A receiver stall holds m_tdata and m_tlast and pauses the emission.
// ----------------------------------------------------------------------------
module random_permutation_shuffle #(
    parameter int MAX_LEN = rps_pkg::MAX_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rps_pkg::VALUE_W-1:0]  s_tdata,   // [7:0] value
    input  logic                         s_tuser,   // [0] cmd
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rps_pkg::VALUE_W-1:0]  m_tdata,   // [7:0] element
    output logic                         m_tlast
);

    rps_pkg::cmd_t    cmd;
    rps_pkg::status_t status;

    rps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rps_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .value   (s_tdata),
        .status  (status),
        .element (m_tdata),
        .last    (m_tlast)
    );

endmodule
